// ===== src/bmhq_pkg.sv =====
// Shared types, constants and the microcode table of the min-heap queue.
`timescale 1ns / 1ps
package bmhq_pkg;

    // Heap geometry.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(CAPACITY);

    // One stored entry: key in the high half, payload in the low half.
    typedef struct packed {
        logic signed [31:0] key;
        logic        [31:0] payload;
    } t_entry;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Command codes.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    // Microprogram step addresses.
    typedef enum logic [4:0] {
        S_IDLE     = 5'd0,
        S_ERRCHK   = 5'd1,
        S_DISPATCH = 5'd2,
        S_INC      = 5'd3,
        S_UP_TEST  = 5'd4,
        S_UP_CMP   = 5'd5,
        S_UP_MOVE  = 5'd6,
        S_UP_PUT   = 5'd7,
        S_REM0     = 5'd8,
        S_REM1     = 5'd9,
        S_REM2     = 5'd10,
        S_DN_TEST  = 5'd11,
        S_DN_L     = 5'd12,
        S_DN_R     = 5'd13,
        S_DN_CMP   = 5'd14,
        S_DN_MOVE  = 5'd15,
        S_DN_PUT   = 5'd16,
        S_DONE     = 5'd17
    } t_step;

    // Read address source.
    typedef enum logic [2:0] {
        RS_NONE, RS_PARENT, RS_ZERO, RS_LAST, RS_LEFT, RS_RIGHT
    } t_rsel;

    // Write data source (address is always the current index).
    typedef enum logic [1:0] {
        WS_NONE, WS_RD, WS_A, WS_CUR
    } t_wsel;

    // Register update performed by a step.
    typedef enum logic [3:0] {
        A_NONE, A_LATCH, A_CNT_INC, A_UP_STEP, A_REM_START, A_TOP_LOAD,
        A_CUR_LOAD, A_C_LEFT, A_A_LOAD, A_PICK, A_DN_STEP, A_OUT_LOAD
    } t_act;

    // Jump conditions.
    typedef enum logic [3:0] {
        C_NEVER, C_ALWAYS, C_ACCEPT, C_ERR, C_REM, C_IDX_ZERO,
        C_UP_STOP, C_NO_LEFT, C_DN_STOP, C_OUT_FREE
    } t_cond;

    // One control word.
    typedef struct packed {
        t_rsel rsel;
        t_wsel wsel;
        t_act  act;
        t_cond cond;
        logic  hold;
        t_step tgt;
    } t_uword;

    // Datapath flags seen by the sequencer.
    typedef struct packed {
        logic accept;
        logic err;
        logic rem;
        logic idx_zero;
        logic up_stop;
        logic no_left;
        logic dn_stop;
        logic out_free;
    } t_flags;

    // Signed key comparison: true when a sorts strictly before b.
    function automatic logic key_less(input t_entry a, input t_entry b);
        return $signed(a.key) < $signed(b.key);
    endfunction

    // The microprogram. A failed condition falls through, or waits when hold is set.
    function automatic t_uword micro_rom(input t_step step);
        t_uword w;
        w = '{RS_NONE, WS_NONE, A_NONE, C_ALWAYS, 1'b0, S_IDLE};
        case (step)
            S_IDLE:     w = '{RS_NONE,   WS_NONE, A_LATCH,     C_ACCEPT,   1'b1, S_ERRCHK};
            S_ERRCHK:   w = '{RS_NONE,   WS_NONE, A_NONE,      C_ERR,      1'b0, S_DONE};
            S_DISPATCH: w = '{RS_NONE,   WS_NONE, A_NONE,      C_REM,      1'b0, S_REM0};
            S_INC:      w = '{RS_NONE,   WS_NONE, A_CNT_INC,   C_NEVER,    1'b0, S_IDLE};
            S_UP_TEST:  w = '{RS_PARENT, WS_NONE, A_NONE,      C_IDX_ZERO, 1'b0, S_UP_PUT};
            S_UP_CMP:   w = '{RS_NONE,   WS_NONE, A_NONE,      C_UP_STOP,  1'b0, S_UP_PUT};
            S_UP_MOVE:  w = '{RS_NONE,   WS_RD,   A_UP_STEP,   C_ALWAYS,   1'b0, S_UP_TEST};
            S_UP_PUT:   w = '{RS_NONE,   WS_CUR,  A_NONE,      C_ALWAYS,   1'b0, S_DONE};
            S_REM0:     w = '{RS_ZERO,   WS_NONE, A_REM_START, C_NEVER,    1'b0, S_IDLE};
            S_REM1:     w = '{RS_LAST,   WS_NONE, A_TOP_LOAD,  C_NEVER,    1'b0, S_IDLE};
            S_REM2:     w = '{RS_NONE,   WS_NONE, A_CUR_LOAD,  C_NEVER,    1'b0, S_IDLE};
            S_DN_TEST:  w = '{RS_LEFT,   WS_NONE, A_C_LEFT,    C_NO_LEFT,  1'b0, S_DN_PUT};
            S_DN_L:     w = '{RS_RIGHT,  WS_NONE, A_A_LOAD,    C_NEVER,    1'b0, S_IDLE};
            S_DN_R:     w = '{RS_NONE,   WS_NONE, A_PICK,      C_NEVER,    1'b0, S_IDLE};
            S_DN_CMP:   w = '{RS_NONE,   WS_NONE, A_NONE,      C_DN_STOP,  1'b0, S_DN_PUT};
            S_DN_MOVE:  w = '{RS_NONE,   WS_A,    A_DN_STEP,   C_ALWAYS,   1'b0, S_DN_TEST};
            S_DN_PUT:   w = '{RS_NONE,   WS_CUR,  A_NONE,      C_ALWAYS,   1'b0, S_DONE};
            S_DONE:     w = '{RS_NONE,   WS_NONE, A_OUT_LOAD,  C_OUT_FREE, 1'b1, S_IDLE};
            default:    w = '{RS_NONE,   WS_NONE, A_NONE,      C_ALWAYS,   1'b0, S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== src/bmhq_if.sv =====
// Valid/ready channel interfaces for commands and results of the min-heap queue.
`timescale 1ns / 1ps
interface bmhq_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] key;
    logic        [31:0] payload;

    modport source (output valid, cmd, key, payload, input ready);
    modport sink   (input valid, cmd, key, payload, output ready);
endinterface

interface bmhq_rsp_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [31:0] out_key;
    logic        [31:0] out_payload;
    logic        [6:0]  fill;

    modport source (output valid, status, out_key, out_payload, fill, input ready);
    modport sink   (input valid, status, out_key, out_payload, fill, output ready);
endinterface

// ===== src/binary_min_heap_queue_unit.sv =====
// Top level of the binary min-heap priority queue.
//
//  Channel   Dir  Interface     Fields
//  i_req     in   bmhq_req_if   cmd, key, payload
//  o_rsp     out  bmhq_rsp_if   status, out_key, out_payload, fill
//
// One command is worked at a time; a refused insert or empty remove jumps from the check to the last step.
// An insert repeats test, compare and move per level moved; at the root it skips the compare.
// A remove repeats test, child reads, compare and move per level; one read port sets this.
// A new command is taken while a result waits; its last step stalls until that transfer.
// Reset empties the heap at once; the entry memory itself is never cleared.
`timescale 1ns / 1ps
module binary_min_heap_queue_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmhq_req_if.sink   i_req,
    bmhq_rsp_if.source o_rsp
);

    localparam int IW = bmhq_pkg::IDX_W;
    localparam int CW = bmhq_pkg::CNT_W;

    bmhq_pkg::t_uword  cw;
    bmhq_pkg::t_flags  flags;
    logic              fire;
    logic              idle;
    logic              accept;

    logic [CW-1:0]     r_cnt;
    logic [IW-1:0]     r_idx;
    logic [CW-1:0]     r_c;
    logic              r_rem;
    bmhq_pkg::t_status r_status;
    bmhq_pkg::t_entry  r_cur;
    bmhq_pkg::t_entry  r_a;
    bmhq_pkg::t_entry  r_top;
    bmhq_pkg::t_entry  rd_data;

    logic              r_out_valid;
    bmhq_pkg::t_status r_out_status;
    bmhq_pkg::t_entry  r_out_entry;
    logic [CW-1:0]     r_out_fill;

    logic [CW-1:0]     left;
    logic [CW-1:0]     right;
    logic [IW-1:0]     parent;
    logic [IW-1:0]     raddr;
    logic              re;
    logic              we;
    bmhq_pkg::t_entry  wdata;
    logic              out_free;
    bmhq_pkg::t_status new_status;

    bmhq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_cw    (cw),
        .o_fire  (fire),
        .o_idle  (idle)
    );

    bmhq_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_idx),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // Input handshake: commands are taken only in the idle step.
    assign i_req.ready = idle;
    assign accept      = i_req.valid && idle;
    assign out_free    = !r_out_valid || o_rsp.ready;

    // Tree neighbours of the current index.
    assign left   = CW'({r_idx, 1'b1});
    assign right  = r_c + CW'(1);
    assign parent = IW'((r_idx - IW'(1)) >> 1);

    // Status of a command as it arrives.
    always_comb begin
        if (i_req.cmd == bmhq_pkg::CMD_INSERT && r_cnt >= bmhq_pkg::FILL_MAX) begin
            new_status = bmhq_pkg::ST_FULL;
        end else if (i_req.cmd == bmhq_pkg::CMD_REMOVE && r_cnt == '0) begin
            new_status = bmhq_pkg::ST_EMPTY;
        end else begin
            new_status = bmhq_pkg::ST_OK;
        end
    end

    // Flags for the sequencer.
    always_comb begin
        flags.accept   = accept;
        flags.err      = (r_status != bmhq_pkg::ST_OK);
        flags.rem      = r_rem;
        flags.idx_zero = (r_idx == '0);
        flags.up_stop  = !bmhq_pkg::key_less(r_cur, rd_data);
        flags.no_left  = (left >= r_cnt);
        flags.dn_stop  = !bmhq_pkg::key_less(r_a, r_cur);
        flags.out_free = out_free;
    end

    // Memory read address.
    always_comb begin
        re    = 1'b1;
        raddr = '0;
        case (cw.rsel)
            bmhq_pkg::RS_NONE:   re    = 1'b0;
            bmhq_pkg::RS_PARENT: raddr = parent;
            bmhq_pkg::RS_ZERO:   raddr = '0;
            bmhq_pkg::RS_LAST:   raddr = r_cnt[IW-1:0];
            bmhq_pkg::RS_LEFT:   raddr = left[IW-1:0];
            bmhq_pkg::RS_RIGHT:  raddr = right[IW-1:0];
            default:             re    = 1'b0;
        endcase
    end

    // Memory write data, always at the current index.
    always_comb begin
        we    = 1'b1;
        wdata = r_cur;
        case (cw.wsel)
            bmhq_pkg::WS_NONE: we    = 1'b0;
            bmhq_pkg::WS_RD:   wdata = rd_data;
            bmhq_pkg::WS_A:    wdata = r_a;
            bmhq_pkg::WS_CUR:  wdata = r_cur;
            default:           we    = 1'b0;
        endcase
    end

    // Control registers: entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (fire && cw.act == bmhq_pkg::A_CNT_INC) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (fire && cw.act == bmhq_pkg::A_REM_START) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // Datapath registers, updated by the step's action.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            case (cw.act)
                bmhq_pkg::A_LATCH: begin
                    r_cur    <= '{key: i_req.key, payload: i_req.payload};
                    r_idx    <= r_cnt[IW-1:0];
                    r_top    <= '0;
                    r_rem    <= (i_req.cmd == bmhq_pkg::CMD_REMOVE);
                    r_status <= new_status;
                end
                bmhq_pkg::A_UP_STEP:   r_idx <= parent;
                bmhq_pkg::A_REM_START: r_idx <= '0;
                bmhq_pkg::A_TOP_LOAD:  r_top <= rd_data;
                bmhq_pkg::A_CUR_LOAD:  r_cur <= rd_data;
                bmhq_pkg::A_C_LEFT:    r_c   <= left;
                bmhq_pkg::A_A_LOAD:    r_a   <= rd_data;
                bmhq_pkg::A_PICK: begin
                    // The right child wins only when it is strictly smaller.
                    if (right < r_cnt && bmhq_pkg::key_less(rd_data, r_a)) begin
                        r_a <= rd_data;
                        r_c <= right;
                    end
                end
                bmhq_pkg::A_DN_STEP:   r_idx <= r_c[IW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Output register: loaded by the final step, cleared on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && cw.act == bmhq_pkg::A_OUT_LOAD) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && cw.act == bmhq_pkg::A_OUT_LOAD) begin
            r_out_status <= r_status;
            r_out_entry  <= r_top;
            r_out_fill   <= r_cnt;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.out_key     = r_out_entry.key;
    assign o_rsp.out_payload = r_out_entry.payload;
    assign o_rsp.fill        = r_out_fill;

endmodule

// ===== src/bmhq_store.sv =====
// Heap entry memory: one write port and one read port with registered data.
`timescale 1ns / 1ps
module bmhq_store (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [bmhq_pkg::IDX_W-1:0] i_waddr,
    input  bmhq_pkg::t_entry          i_wdata,
    input  logic                      i_re,
    input  logic [bmhq_pkg::IDX_W-1:0] i_raddr,
    output bmhq_pkg::t_entry          o_rdata
);

    bmhq_pkg::t_entry r_mem [bmhq_pkg::CAPACITY];
    bmhq_pkg::t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bmhq_seq.sv =====
// Microprogram sequencer: step counter, control table and conditional jumps.
`timescale 1ns / 1ps
module bmhq_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmhq_pkg::t_flags  i_flags,
    output bmhq_pkg::t_uword  o_cw,
    output logic              o_fire,
    output logic              o_idle
);

    bmhq_pkg::t_step  r_upc;
    bmhq_pkg::t_step  n_upc;
    bmhq_pkg::t_uword cw;
    logic             cond_true;

    // Fetch the control word of the current step.
    assign cw = bmhq_pkg::micro_rom(r_upc);

    // Evaluate the jump condition.
    always_comb begin
        case (cw.cond)
            bmhq_pkg::C_NEVER:    cond_true = 1'b0;
            bmhq_pkg::C_ALWAYS:   cond_true = 1'b1;
            bmhq_pkg::C_ACCEPT:   cond_true = i_flags.accept;
            bmhq_pkg::C_ERR:      cond_true = i_flags.err;
            bmhq_pkg::C_REM:      cond_true = i_flags.rem;
            bmhq_pkg::C_IDX_ZERO: cond_true = i_flags.idx_zero;
            bmhq_pkg::C_UP_STOP:  cond_true = i_flags.up_stop;
            bmhq_pkg::C_NO_LEFT:  cond_true = i_flags.no_left;
            bmhq_pkg::C_DN_STOP:  cond_true = i_flags.dn_stop;
            bmhq_pkg::C_OUT_FREE: cond_true = i_flags.out_free;
            default:              cond_true = 1'b0;
        endcase
    end

    // Next step: jump, wait in place, or fall through.
    always_comb begin
        if (cond_true) begin
            n_upc = cw.tgt;
        end else if (cw.hold) begin
            n_upc = r_upc;
        end else begin
            n_upc = bmhq_pkg::t_step'(r_upc + 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= bmhq_pkg::S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_cw   = cw;
    assign o_fire = cond_true || !cw.hold;
    assign o_idle = (r_upc == bmhq_pkg::S_IDLE);

endmodule

// ===== src/bmhq_chk.sv =====
// Port-level checker for the min-heap queue, bound to the top level.
`timescale 1ns / 1ps
module bmhq_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [1:0]         i_status,
    input logic signed [31:0] i_out_key,
    input logic [31:0]        i_out_payload,
    input logic [6:0]         i_fill
);

    // A pending result stays offered until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> i_valid)
        else $error("result withdrawn before transfer");

    // The fill count never exceeds the capacity.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_fill <= bmhq_pkg::FILL_MAX))
        else $error("fill beyond capacity");

    // A remove on an empty heap reports zero entry and an empty heap.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status == bmhq_pkg::ST_EMPTY) |->
            (i_out_key == '0 && i_out_payload == '0 && i_fill == '0))
        else $error("empty remove result not cleared");

    // A refused insert is only reported with the heap at capacity.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status == bmhq_pkg::ST_FULL) |->
            (i_fill == bmhq_pkg::FILL_MAX && i_out_key == '0 && i_out_payload == '0))
        else $error("full status with room left");

    // No result is offered in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result offered after reset");

endmodule

bind binary_min_heap_queue_unit bmhq_chk u_bmhq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_rsp.valid),
    .i_ready       (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_out_key     (o_rsp.out_key),
    .i_out_payload (o_rsp.out_payload),
    .i_fill        (o_rsp.fill)
);

// ===== tb/binary_min_heap_queue_unit_test.sv =====
// Self-checking testbench for the binary min-heap priority queue unit.
`timescale 1ns / 1ps
module binary_min_heap_queue_unit_test;
    import bmhq_pkg::*;

    // Expected content of one result transfer.
    typedef struct packed {
        t_status            status;
        logic signed [31:0] key;
        logic        [31:0] payload;
        logic [CNT_W-1:0]   fill;
    } t_outcome;

    // One row of the directed table; the outcome is used only when typed is set.
    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] key;
        logic        [31:0] payload;
        logic               typed;
        t_outcome           outcome;
    } t_stim_row;

    // Command mix of one random burst.
    typedef enum logic [1:0] {
        MIX_FILL, MIX_DRAIN, MIX_BALANCED
    } t_mix;

    localparam int       RANDOM_ITEMS = 1030;
    localparam int       QUIET_TAIL   = 150;
    localparam int       HOLD_AFTER   = 250;
    localparam int       HOLD_CYCLES  = 320;
    localparam int       STALL_LIMIT  = 3000;
    localparam int       DRAIN_CYCLES = 60;
    localparam t_outcome NO_OUTCOME   = '{ST_OK, 32'sd0, 32'h0, 7'd0};
    localparam int       N_ROWS       = 21;

    // Directed table: empty remove, key extremes, then equal keys and alternating bit patterns.
    localparam t_stim_row DIRECTED_ROWS [N_ROWS] = '{
        '{CMD_REMOVE, 32'sd0,          32'h0,         1'b1, '{ST_EMPTY, 32'sd0, 32'h0, 7'd0}},
        '{CMD_INSERT, 32'sh8000_0000,  32'h0000_0000, 1'b1, '{ST_OK, 32'sd0, 32'h0, 7'd1}},
        '{CMD_INSERT, 32'sh7FFF_FFFF,  32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'sd0, 32'h0, 7'd2}},
        '{CMD_REMOVE, 32'sh1234_5678,  32'h9ABC_DEF0, 1'b1,
          '{ST_OK, 32'sh8000_0000, 32'h0000_0000, 7'd1}},
        '{CMD_REMOVE, 32'sd0,          32'h0,         1'b1,
          '{ST_OK, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 7'd0}},
        '{CMD_REMOVE, 32'sd0,          32'h0,         1'b1, '{ST_EMPTY, 32'sd0, 32'h0, 7'd0}},
        '{CMD_INSERT, 32'sd5,          32'h5555_5555, 1'b0, NO_OUTCOME},
        '{CMD_INSERT, 32'sd5,          32'hAAAA_AAAA, 1'b0, NO_OUTCOME},
        '{CMD_INSERT, -32'sd1,         32'h0000_0001, 1'b0, NO_OUTCOME},
        '{CMD_INSERT, 32'sd5,          32'h0000_0002, 1'b0, NO_OUTCOME},
        '{CMD_INSERT, 32'sd0,          32'h8000_0000, 1'b0, NO_OUTCOME},
        '{CMD_INSERT, -32'sd1,         32'h0000_0003, 1'b0, NO_OUTCOME},
        '{CMD_INSERT, 32'sd5,          32'h0000_0004, 1'b0, NO_OUTCOME},
        '{CMD_REMOVE, 32'sd0,          32'h0,         1'b0, NO_OUTCOME},
        '{CMD_REMOVE, 32'sh7FFF_FFFF,  32'hFFFF_FFFF, 1'b0, NO_OUTCOME},
        '{CMD_REMOVE, 32'sd0,          32'h0,         1'b0, NO_OUTCOME},
        '{CMD_REMOVE, 32'sd0,          32'h0,         1'b0, NO_OUTCOME},
        '{CMD_REMOVE, 32'sh8000_0000,  32'h0,         1'b0, NO_OUTCOME},
        '{CMD_REMOVE, 32'sd0,          32'h0,         1'b0, NO_OUTCOME},
        '{CMD_REMOVE, 32'sd0,          32'h0,         1'b0, NO_OUTCOME},
        '{CMD_REMOVE, 32'sd0,          32'h0,         1'b1, '{ST_EMPTY, 32'sd0, 32'h0, 7'd0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    bmhq_req_if req_bus ();
    bmhq_rsp_if rsp_bus ();

    binary_min_heap_queue_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow copy of the heap and the results still owed by the block.
    t_entry      heap_image [CAPACITY];
    int unsigned heap_size;
    t_outcome    owed_outcomes [$];

    int unsigned commands_accepted;
    int unsigned results_seen;
    int unsigned mismatch_count;
    int unsigned refused_inserts;
    int unsigned empty_removes;
    int unsigned insert_count;
    int unsigned peak_fill;
    int unsigned stalled_cycles;
    bit          quiet_tail;

    always #6 i_clk = ~i_clk;

    // Applies one command to the shadow heap and returns the result it must produce.
    function automatic t_outcome apply_heap_command(input t_cmd c, input t_entry e);
        t_outcome    o;
        t_entry      tmp;
        int unsigned i;
        int unsigned p;
        int unsigned ch;
        o = NO_OUTCOME;
        if (c == CMD_INSERT) begin
            insert_count++;
            if (heap_size >= CAPACITY) begin
                o.status = ST_FULL;
                refused_inserts++;
            end else begin
                i = heap_size;
                heap_image[i] = e;
                heap_size++;
                // Sift up while strictly smaller than the parent.
                while (i != 0) begin
                    p = (i - 1) / 2;
                    if (!($signed(heap_image[i].key) < $signed(heap_image[p].key)))
                        break;
                    tmp = heap_image[i];
                    heap_image[i] = heap_image[p];
                    heap_image[p] = tmp;
                    i = p;
                end
            end
        end else begin
            if (heap_size == 0) begin
                o.status = ST_EMPTY;
                empty_removes++;
            end else begin
                o.key = heap_image[0].key;
                o.payload = heap_image[0].payload;
                heap_image[0] = heap_image[heap_size - 1];
                heap_size--;
                i = 0;
                // Sift down; the right child wins only when strictly smaller.
                while (2 * i + 1 < heap_size) begin
                    ch = 2 * i + 1;
                    if (ch + 1 < heap_size &&
                        $signed(heap_image[ch + 1].key) < $signed(heap_image[ch].key))
                        ch++;
                    if (!($signed(heap_image[ch].key) < $signed(heap_image[i].key)))
                        break;
                    tmp = heap_image[i];
                    heap_image[i] = heap_image[ch];
                    heap_image[ch] = tmp;
                    i = ch;
                end
            end
        end
        o.fill = CNT_W'(heap_size);
        if (heap_size > peak_fill)
            peak_fill = heap_size;
        return o;
    endfunction

    // Random key: mostly full range, some narrow to force ties, some extremes.
    function automatic logic signed [31:0] pick_key();
        logic signed [31:0] k;
        case ($urandom_range(0, 7))
            0, 1: k = $signed(32'($urandom_range(0, 6))) - 32'sd3;
            2: begin
                case ($urandom_range(0, 3))
                    0:       k = 32'sh8000_0000;
                    1:       k = 32'sh7FFF_FFFF;
                    2:       k = 32'sd0;
                    default: k = -32'sd1;
                endcase
            end
            default: k = $signed($urandom);
        endcase
        return k;
    endfunction

    // Offers one command, waits for its transfer and records the result it owes.
    task automatic offer_command(input t_cmd c, input logic signed [31:0] k,
                                 input logic [31:0] p, input logic typed,
                                 input t_outcome typed_outcome);
        t_outcome predicted;
        t_entry   e;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.cmd     <= c;
        req_bus.key     <= k;
        req_bus.payload <= p;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        e.key = k;
        e.payload = p;
        predicted = apply_heap_command(c, e);
        owed_outcomes.push_back(typed ? typed_outcome : predicted);
        commands_accepted++;
    endtask

    // Compares one result transfer with the oldest owed outcome.
    task automatic check_result_transfer();
        t_outcome want;
        results_seen++;
        if (owed_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("tb: unexpected result: status %0d key %0d payload %h fill %0d",
                         rsp_bus.status, rsp_bus.out_key, rsp_bus.out_payload, rsp_bus.fill);
            return;
        end
        want = owed_outcomes.pop_front();
        if (rsp_bus.status !== want.status || rsp_bus.out_key !== want.key ||
            rsp_bus.out_payload !== want.payload || rsp_bus.fill !== want.fill) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("tb: result %0d expected status %0d key %0d payload %h fill %0d, %s",
                         results_seen, want.status, want.key, want.payload, want.fill,
                         $sformatf("got status %0d key %0d payload %h fill %0d",
                                   rsp_bus.status, rsp_bus.out_key, rsp_bus.out_payload,
                                   rsp_bus.fill));
        end
    endtask

    // Result side: checks transfers and stalls in bursts, once for a long stretch.
    initial begin : result_sink
        int unsigned stall_left;
        bit          long_hold_done;
        stall_left = 0;
        long_hold_done = 1'b0;
        rsp_bus.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
                check_result_transfer();
            if (!long_hold_done && commands_accepted >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left != 0) begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= STALL_LIMIT) begin
            $display("tb: no transfer for %0d cycles, %0d results still owed",
                     stalled_cycles, owed_outcomes.size());
            $display("tb: failure");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // Command side: reset, directed table, random bursts, then drain and verdict.
    initial begin : command_source
        t_mix        mix;
        int unsigned burst_left;
        int unsigned burst_no;
        int unsigned insert_pct;
        t_cmd        c;
        i_rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.cmd = CMD_INSERT;
        req_bus.key = '0;
        req_bus.payload = '0;
        heap_size = 0;
        commands_accepted = 0;
        results_seen = 0;
        mismatch_count = 0;
        refused_inserts = 0;
        empty_removes = 0;
        insert_count = 0;
        peak_fill = 0;
        stalled_cycles = 0;
        quiet_tail = 1'b0;
        burst_left = 0;
        burst_no = 0;
        insert_pct = 50;
        mix = MIX_BALANCED;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        foreach (DIRECTED_ROWS[r])
            offer_command(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].payload,
                          DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].outcome);

        // Random bursts; the first two fill past capacity and drain past empty.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                if (burst_no == 0) begin
                    mix = MIX_FILL;
                    insert_pct = 100;
                    burst_left = CAPACITY + 8;
                end else if (burst_no == 1) begin
                    mix = MIX_DRAIN;
                    insert_pct = 0;
                    burst_left = CAPACITY + 8;
                end else begin
                    mix = t_mix'($urandom_range(0, 2));
                    insert_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
                    burst_left = $urandom_range(20, 90);
                end
                burst_no++;
            end
            burst_left--;
            quiet_tail = (n >= RANDOM_ITEMS - QUIET_TAIL);
            c = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            offer_command(c, pick_key(), $urandom, 1'b0, NO_OUTCOME);
        end
        req_bus.valid <= 1'b0;

        // Wait for every owed result, then let the block settle.
        while (owed_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d commands (%0d inserts), %0d results, peak fill %0d",
                 commands_accepted, insert_count, results_seen, peak_fill);
        $display("tb: %0d inserts refused on a full heap, %0d removes on an empty heap",
                 refused_inserts, empty_removes);
        if (mismatch_count == 0 && owed_outcomes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", mismatch_count);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/bmhq_pkg.sv
src/bmhq_if.sv
src/bmhq_store.sv
src/bmhq_seq.sv
src/binary_min_heap_queue_unit.sv
src/bmhq_chk.sv
tb/binary_min_heap_queue_unit_test.sv
